>>> hw/rtl/hll_pkg.sv
// Shared types and codes for the HyperLogLog sketch update block.
// No dependencies; front, back and top use it by scoped names.
`default_nettype none

package hll_pkg;

  // Command codes of the input beat
  localparam logic [1:0] CMD_INSERT    = 2'd0;
  localparam logic [1:0] CMD_MERGE     = 2'd1;
  localparam logic [1:0] CMD_READ_SLOT = 2'd2;
  localparam logic [1:0] CMD_READ_BIN  = 2'd3;

  // Width of a rank value and of the result data
  localparam int RANK_W = 6;
  localparam int DATA_W = 7;

  typedef struct packed {
    logic [1:0]        command;
    logic [63:0]       hash_value;
    logic [RANK_W-1:0] slot;
    logic [RANK_W-1:0] incoming_rank;
    logic [RANK_W-1:0] bin_number;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              updated;
  } out_item_t;

  // Classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_RAISE    = 2'd0,  // insert or merge: max into a register
    OP_READ_REG = 2'd1,
    OP_READ_BIN = 2'd2,
    OP_READ_ZERO = 2'd3  // bin beyond the histogram
  } op_t;

  // value: rank for OP_RAISE, bin for OP_READ_BIN
  typedef struct packed {
    op_t               op;
    logic [RANK_W-1:0] value;
  } q_cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_REG,
    ST_CHK,
    ST_HIST_RD_OLD,
    ST_HIST_DEC,
    ST_HIST_RD_NEW,
    ST_HIST_INC,
    ST_RD_BIN,
    ST_BIN_CAP,
    ST_FINISH
  } back_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/hll_queue.sv
// Small FIFO between the front and back parts of the sketch block.
// Generic payload width; no package dependencies.
`default_nettype none

module hll_queue #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count != CNTW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push_fire, pop_fire})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hll_front.sv
// Front part: accepts input beats, classifies the command and computes the rank.
// Uses hll_pkg (in_item_t, q_cmd_t, op_t, command codes).
`default_nettype none

module hll_front #(
  parameter int INDEX_BITS = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire hll_pkg::in_item_t     cmd,
  input  wire logic                  hold,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output hll_pkg::q_cmd_t            push_cmd,
  output logic [INDEX_BITS-1:0]      push_index
);

  localparam int RW   = 65 - INDEX_BITS;       // rank bits plus guard
  localparam int NG   = (RW + 7) / 8;          // byte groups
  localparam int PW   = NG * 8;
  localparam int SELW = $clog2(NG);
  localparam int SW   = (INDEX_BITS > 6) ? INDEX_BITS : 6;
  localparam logic [5:0] MAX_RANK  = 6'(RW);
  localparam logic [5:0] BIN_LIMIT = 6'(RW + 1);

  // input side, combinational
  logic [PW-1:0]         rest_pad;
  logic [NG-1:0]         g_nz;
  logic [2:0]            g_tz [NG];
  logic [SW-1:0]         slot_ext;
  hll_pkg::op_t          d_op;
  logic                  d_ins;
  logic [5:0]            d_value;
  logic [INDEX_BITS-1:0] d_index;

  // stage register
  logic                  a_valid;
  logic                  a_ins;
  hll_pkg::op_t          a_op;
  logic [5:0]            a_value;
  logic [INDEX_BITS-1:0] a_index;
  logic [NG-1:0]         a_nz;
  logic [2:0]            a_tz [NG];

  logic [SELW-1:0]       sel;
  logic [5:0]            rank;
  logic                  accept;

  always_comb begin
    rest_pad = PW'({1'b1, cmd.hash_value[63:INDEX_BITS]});
    for (int g = 0; g < NG; g++) begin
      g_nz[g] = |rest_pad[g*8 +: 8];
      g_tz[g] = 3'd0;
      for (int b = 7; b >= 0; b--) begin
        if (rest_pad[g*8 + b]) begin
          g_tz[g] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    slot_ext = SW'(cmd.slot);
    d_op     = hll_pkg::OP_READ_ZERO;
    d_ins    = 1'b0;
    d_value  = '0;
    d_index  = slot_ext[INDEX_BITS-1:0];
    case (cmd.command)
      hll_pkg::CMD_INSERT: begin
        d_op    = hll_pkg::OP_RAISE;
        d_ins   = 1'b1;
        d_index = cmd.hash_value[INDEX_BITS-1:0];
      end
      hll_pkg::CMD_MERGE: begin
        d_op    = hll_pkg::OP_RAISE;
        d_value = (cmd.incoming_rank > MAX_RANK) ? MAX_RANK : cmd.incoming_rank;
      end
      hll_pkg::CMD_READ_SLOT: begin
        d_op = hll_pkg::OP_READ_REG;
      end
      hll_pkg::CMD_READ_BIN: begin
        d_op    = (cmd.bin_number < BIN_LIMIT) ? hll_pkg::OP_READ_BIN
                                               : hll_pkg::OP_READ_ZERO;
        d_value = cmd.bin_number;
      end
      default: begin
        d_op = hll_pkg::OP_READ_ZERO;
      end
    endcase
  end

  assign cmd_ready = (!a_valid || push_ready) && !hold;
  assign accept    = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (push_ready) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_ins   <= d_ins;
      a_op    <= d_op;
      a_value <= d_value;
      a_index <= d_index;
      a_nz    <= g_nz;
      for (int g = 0; g < NG; g++) begin
        a_tz[g] <= g_tz[g];
      end
    end
  end

  // first nonzero group; the guard bit keeps at least one set
  always_comb begin
    sel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (a_nz[g]) begin
        sel = SELW'(g);
      end
    end
    rank = 6'({sel, a_tz[sel]}) + 6'd1;
  end

  assign push_valid     = a_valid;
  assign push_cmd.op    = a_op;
  assign push_cmd.value = a_ins ? rank : a_value;
  assign push_index     = a_index;

endmodule

`default_nettype wire

>>> hw/rtl/hll_back.sv
// Back part: register file, histogram memory, update sequencer and result register.
// Uses hll_pkg (q_cmd_t, op_t, back_state_t, out_item_t).
`default_nettype none

module hll_back #(
  parameter int INDEX_BITS = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pop_valid,
  output logic                       pop_ready,
  input  wire hll_pkg::q_cmd_t       pop_cmd,
  input  wire logic [INDEX_BITS-1:0] pop_index,
  output logic                       clearing,
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  output hll_pkg::out_item_t         rsp
);

  localparam int NUM_REGS = 1 << INDEX_BITS;
  localparam int NUM_BINS = 66 - INDEX_BITS;
  localparam int BW       = $clog2(NUM_BINS);
  localparam int CW       = INDEX_BITS + 1;          // histogram count width
  localparam int XW       = (CW > 7) ? CW : 7;
  localparam int CLRN     = (NUM_REGS > NUM_BINS) ? NUM_REGS : NUM_BINS;
  localparam int CLRW     = $clog2(CLRN);
  localparam logic [CW-1:0] HIST_INIT = CW'(NUM_REGS);

  logic [5:0]    regs [NUM_REGS];
  logic [CW-1:0] hist [NUM_BINS];

  hll_pkg::back_state_t state;
  hll_pkg::back_state_t state_next;

  logic [CLRW-1:0]       clr_cnt;
  hll_pkg::op_t          cur_op;
  logic [INDEX_BITS-1:0] cur_index;
  logic [5:0]            cur_value;
  logic [5:0]            old_val;
  logic [5:0]            reg_q;
  logic [CW-1:0]         hist_q;
  logic [6:0]            res_data;
  logic                  res_upd;

  // sequencer controls
  logic                  reg_we;
  logic [INDEX_BITS-1:0] reg_addr;
  logic [5:0]            reg_wdata;
  logic                  hist_we;
  logic [BW-1:0]         hist_addr;
  logic [CW-1:0]         hist_wdata;
  logic                  load_rsp;
  logic                  do_raise;
  logic                  out_free;
  logic                  clr_last;
  logic [XW-1:0]         hist_ext;

  assign out_free = !rsp_valid || rsp_ready;
  assign clr_last = (clr_cnt == CLRW'(CLRN - 1));
  assign do_raise = (cur_op == hll_pkg::OP_RAISE) && (cur_value > reg_q);
  assign hist_ext = XW'(hist_q);
  assign clearing = (state == hll_pkg::ST_CLEAR);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hll_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = hll_pkg::ST_IDLE;
        end
      end
      hll_pkg::ST_IDLE: begin
        if (pop_valid) begin
          case (pop_cmd.op)
            hll_pkg::OP_RAISE:    state_next = hll_pkg::ST_RD_REG;
            hll_pkg::OP_READ_REG: state_next = hll_pkg::ST_RD_REG;
            hll_pkg::OP_READ_BIN: state_next = hll_pkg::ST_RD_BIN;
            default:              state_next = hll_pkg::ST_FINISH;
          endcase
        end
      end
      hll_pkg::ST_RD_REG:      state_next = hll_pkg::ST_CHK;
      hll_pkg::ST_CHK: begin
        state_next = do_raise ? hll_pkg::ST_HIST_RD_OLD : hll_pkg::ST_FINISH;
      end
      hll_pkg::ST_HIST_RD_OLD: state_next = hll_pkg::ST_HIST_DEC;
      hll_pkg::ST_HIST_DEC:    state_next = hll_pkg::ST_HIST_RD_NEW;
      hll_pkg::ST_HIST_RD_NEW: state_next = hll_pkg::ST_HIST_INC;
      hll_pkg::ST_HIST_INC:    state_next = hll_pkg::ST_FINISH;
      hll_pkg::ST_RD_BIN:      state_next = hll_pkg::ST_BIN_CAP;
      hll_pkg::ST_BIN_CAP:     state_next = hll_pkg::ST_FINISH;
      hll_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = hll_pkg::ST_IDLE;
        end
      end
      default:                 state_next = hll_pkg::ST_CLEAR;
    endcase
  end

  // controls
  always_comb begin
    pop_ready  = 1'b0;
    reg_we     = 1'b0;
    reg_addr   = cur_index;
    reg_wdata  = cur_value;
    hist_we    = 1'b0;
    hist_addr  = BW'(cur_value);
    hist_wdata = hist_q + CW'(1);
    load_rsp   = 1'b0;
    case (state)
      hll_pkg::ST_CLEAR: begin
        reg_addr   = clr_cnt[INDEX_BITS-1:0];
        reg_wdata  = '0;
        reg_we     = ({1'b0, clr_cnt} < (CLRW + 1)'(NUM_REGS));
        hist_addr  = clr_cnt[BW-1:0];
        hist_wdata = (clr_cnt == '0) ? HIST_INIT : '0;
        hist_we    = ({1'b0, clr_cnt} < (CLRW + 1)'(NUM_BINS));
      end
      hll_pkg::ST_IDLE: begin
        pop_ready = 1'b1;
      end
      hll_pkg::ST_CHK: begin
        reg_we = do_raise;
      end
      hll_pkg::ST_HIST_RD_OLD: begin
        hist_addr = BW'(old_val);
      end
      hll_pkg::ST_HIST_DEC: begin
        hist_addr  = BW'(old_val);
        hist_wdata = hist_q - CW'(1);
        hist_we    = (hist_q != '0);
      end
      hll_pkg::ST_HIST_INC: begin
        hist_we = 1'b1;
      end
      hll_pkg::ST_FINISH: begin
        load_rsp = out_free;
      end
      default: begin
        pop_ready = 1'b0;
      end
    endcase
  end

  // register file
  always_ff @(posedge clk) begin
    if (reg_we) begin
      regs[reg_addr] <= reg_wdata;
    end
    reg_q <= regs[reg_addr];
  end

  // histogram
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist[hist_addr] <= hist_wdata;
    end
    hist_q <= hist[hist_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hll_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == hll_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + CLRW'(1);
      end
    end
  end

  // working item and pending result
  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      cur_op    <= pop_cmd.op;
      cur_index <= pop_index;
      cur_value <= pop_cmd.value;
      res_data  <= '0;
      res_upd   <= 1'b0;
    end
    if (state == hll_pkg::ST_CHK) begin
      old_val  <= reg_q;
      res_data <= {1'b0, do_raise ? cur_value : reg_q};
      res_upd  <= do_raise;
    end
    if (state == hll_pkg::ST_BIN_CAP) begin
      res_data <= hist_ext[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.read_data <= res_data;
      rsp.updated   <= res_upd;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hyperloglog_sketch_update.sv
// HyperLogLog sketch update, top level. Keeps 2^INDEX_BITS six-bit rank
// registers and a histogram of their values. Each cmd beat gives exactly one
// rsp beat, in order. Insert: the low INDEX_BITS hash bits pick a register,
// the rank is one plus the trailing zeros of the upper bits (guard bit at
// 64-INDEX_BITS), and the register keeps the max. Merge does the same max
// with slot/incoming_rank (rank saturates at 65-INDEX_BITS). Reads return a
// register or a histogram count (7 bits, masked). After reset a clearing pass
// over both memories runs with cmd_ready low. The back sequencer works on one
// item at a time over single-port register and histogram memories: a raising
// insert or merge reads the register, then updates the old and new histogram
// bins; a non-raising one or a register read ends after the register read, a
// bin read after the bin read, an out-of-range bin read at once. A front stage
// and a small queue hide the front latency and keep accepting beats while the
// back is busy; the result register lets the next item start while a response
// waits for rsp_ready. Depends on hll_pkg, hll_front, hll_queue, hll_back.
`default_nettype none

module hyperloglog_sketch_update #(
  parameter int INDEX_BITS  = 6,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire hll_pkg::in_item_t  cmd,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output hll_pkg::out_item_t      rsp
);

  localparam int CMD_W = $bits(hll_pkg::q_cmd_t);
  localparam int QW    = CMD_W + INDEX_BITS;

  // front -> queue
  logic                  f_push_valid;
  logic                  f_push_ready;
  hll_pkg::q_cmd_t       f_push_cmd;
  logic [INDEX_BITS-1:0] f_push_index;

  // queue -> back
  logic                  q_pop_valid;
  logic                  q_pop_ready;
  logic [QW-1:0]         q_pop_data;
  hll_pkg::q_cmd_t       q_pop_cmd;

  // high while the memories are being initialized
  logic                  clearing;

  hll_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .hold      (clearing),
    .push_valid(f_push_valid),
    .push_ready(f_push_ready),
    .push_cmd  (f_push_cmd),
    .push_index(f_push_index)
  );

  // queue entry: classified op and rank/bin on top, register index below
  hll_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_push_valid),
    .push_ready(f_push_ready),
    .push_data ({f_push_cmd, f_push_index}),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data)
  );

  assign q_pop_cmd = hll_pkg::q_cmd_t'(q_pop_data[QW-1:INDEX_BITS]);

  hll_back #(
    .INDEX_BITS(INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_cmd   (q_pop_cmd),
    .pop_index (q_pop_data[INDEX_BITS-1:0]),
    .clearing  (clearing),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

>>> bench/hll_checker.sv
// Response checker for the HyperLogLog sketch update block: keeps its own copy of the
// rank registers and value histogram, predicts every response and compares in order.
// Depends on hll_pkg for the beat types and command codes.
module hll_checker #(
  parameter int INDEX_BITS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic               cmd_ready,
  input  hll_pkg::in_item_t  cmd,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  hll_pkg::out_item_t rsp,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hll_pkg::*;

  localparam int NUM_SLOTS = 1 << INDEX_BITS;
  localparam int RANK_SPAN = 64 - INDEX_BITS;  // hash bits left for the rank
  localparam int TOP_RANK  = RANK_SPAN + 1;
  localparam int NUM_BINS  = RANK_SPAN + 2;

  logic [RANK_W-1:0] rank_file [NUM_SLOTS];
  int unsigned       value_count [NUM_BINS];
  out_item_t         expected_rsp [$];
  int                fails = 0;
  int                waiting = 0;

  assign fail_count = fails;
  assign pending    = waiting;

  // guard bit keeps the count bounded for an all-zero upper hash
  function automatic int rank_of_hash(input logic [63:0] h);
    logic [63:0] rest;
    int          n;
    rest = (h >> INDEX_BITS) | (64'd1 << RANK_SPAN);
    n = 0;
    while (!rest[n]) n++;
    return n + 1;
  endfunction

  function automatic out_item_t raise_slot(input int idx, input int rank);
    out_item_t r;
    int        old;
    if (rank > TOP_RANK) rank = TOP_RANK;
    old = rank_file[idx];
    r.read_data = DATA_W'(old);
    r.updated   = 1'b0;
    if (rank > old) begin
      if (value_count[old] > 0) value_count[old]--;
      value_count[rank]++;
      rank_file[idx] = RANK_W'(rank);
      r.read_data    = DATA_W'(rank);
      r.updated      = 1'b1;
    end
    return r;
  endfunction

  function automatic out_item_t predict_rsp(input in_item_t c);
    out_item_t r;
    r = '0;
    case (c.command)
      CMD_INSERT: begin
        r = raise_slot(int'(c.hash_value % NUM_SLOTS), rank_of_hash(c.hash_value));
      end
      CMD_MERGE: begin
        r = raise_slot(int'(c.slot) % NUM_SLOTS, int'(c.incoming_rank));
      end
      CMD_READ_SLOT: begin
        r.read_data = DATA_W'(rank_file[int'(c.slot) % NUM_SLOTS]);
      end
      CMD_READ_BIN: begin
        if (c.bin_number < NUM_BINS) r.read_data = DATA_W'(value_count[c.bin_number]);
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      foreach (rank_file[i]) rank_file[i] = '0;
      foreach (value_count[i]) value_count[i] = 0;
      value_count[0] = NUM_SLOTS;
      expected_rsp.delete();
    end else begin
      // results before commands: a beat accepted now cannot answer itself
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $error("unexpected response beat: read_data %0d updated %0b",
                 rsp.read_data, rsp.updated);
          fails++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.read_data !== want.read_data) begin
            $error("read_data mismatch: expected %0d, got %0d", want.read_data, rsp.read_data);
            fails++;
          end
          if (rsp.updated !== want.updated) begin
            $error("updated mismatch: expected %0b, got %0b", want.updated, rsp.updated);
            fails++;
          end
        end
      end
      if (cmd_valid && cmd_ready) expected_rsp.push_back(predict_rsp(cmd));
    end
    waiting = expected_rsp.size();
  end

endmodule

>>> bench/tb_top.sv
// Top of the HyperLogLog sketch update bench: clock, reset, command stimulus,
// response back-pressure and the verdict. Depends on hll_pkg, hll_checker and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hll_pkg::*;

  localparam int IDLE_MAX     = 16;
  localparam int RANDOM_ITEMS = 880;
  localparam int HOLD_AT      = 300;   // response count at which the long hold starts
  localparam int HOLD_CYCLES  = 300;
  localparam int PAUSE_AT     = 600;   // random beat index where the sender drains out
  localparam int DRAIN_CYCLES = 20;    // > the worst case of one raise
  localparam int QUIET_LIMIT  = 3000;  // covers the clear pass and the long hold

  logic      clk;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  in_item_t  cmd = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  out_item_t rsp;
  int        fail_count;
  int        pending;
  int        quiet = 0;

  // sender idling: runs of beats either with random gaps or back to back
  int        tx_run_left = 0;
  bit        tx_no_idle = 1'b0;

  hyperloglog_sketch_update u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  hll_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any accepted beat on either channel restarts the count.
  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("FAIL hyperloglog_sketch_update");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic in_item_t pack_beat(input logic [1:0] op, input logic [63:0] h,
                                         input int s, input int r, input int b);
    in_item_t it;
    it.command       = op;
    it.hash_value    = h;
    it.slot          = RANK_W'(s);
    it.incoming_rank = RANK_W'(r);
    it.bin_number    = RANK_W'(b);
    return it;
  endfunction

  // Random beat: every field is filled with random bits whatever the command,
  // then the command and the interesting fields are shaped.
  function automatic in_item_t random_beat();
    in_item_t it;
    int       pick;
    int       tz;
    it.hash_value    = {$urandom(), $urandom()};
    it.slot          = RANK_W'($urandom_range(0, 63));
    it.incoming_rank = RANK_W'($urandom_range(0, 63));
    it.bin_number    = RANK_W'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.command = CMD_INSERT;
      // plain random hashes almost never rank above a few; clear a run of low
      // rank bits in a third of them so high ranks and the guard bit show up
      if ($urandom_range(0, 2) == 0) begin
        tz = $urandom_range(0, 58);
        it.hash_value &= ~(((64'd1 << tz) - 64'd1) << 6);
      end
    end else if (pick < 70) begin
      it.command = CMD_MERGE;
      // keep half the merges low so registers do not all saturate early
      if ($urandom_range(0, 1) == 0) it.incoming_rank = RANK_W'($urandom_range(0, 20));
    end else if (pick < 85) begin
      it.command = CMD_READ_SLOT;
    end else begin
      it.command = CMD_READ_BIN;
    end
    return it;
  endfunction

  // Entered at a falling edge right after the previous beat went through, so a
  // gap drops valid before the stale payload could be taken again. With no gap
  // valid stays high and only the payload changes.
  task automatic send_beat(input in_item_t it);
    int gap;
    if (tx_run_left == 0) begin
      tx_run_left = $urandom_range(10, 60);
      tx_no_idle  = ($urandom_range(0, 2) == 0);
    end
    tx_run_left--;
    gap = tx_no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= it;
    do @(posedge clk); while (!cmd_ready);
    @(negedge clk);
  endtask

  // Response side: per beat a random stall, runs with none at all, and one long
  // hold so the queue inside the block fills and cmd_ready drops.
  initial begin : rx_side
    int gap;
    int got;
    int run_left;
    bit no_idle;
    got      = 0;
    run_left = 0;
    no_idle  = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (run_left == 0) begin
        run_left = $urandom_range(10, 60);
        no_idle  = ($urandom_range(0, 2) == 0);
      end
      run_left--;
      gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
      if (got == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      got++;
      @(negedge clk);
    end
  end

  initial begin : tx_side
    int n;
    // synchronous reset first; the block then clears its memories
    // with cmd_ready low, and the first beat simply waits that out
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed part: fresh-sketch reads, guard-bit rank, rank one, top slots,
    // saturating merge, merges that do not raise, bins past the histogram.
    send_beat(pack_beat(CMD_READ_BIN,  64'd0, 0, 0, 0));       // all registers in bin zero
    send_beat(pack_beat(CMD_READ_SLOT, 64'd0, 0, 0, 0));
    send_beat(pack_beat(CMD_INSERT,    64'd0, 0, 0, 0));       // upper bits zero: guard rank
    send_beat(pack_beat(CMD_INSERT,    64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));  // slot 63, rank 1
    send_beat(pack_beat(CMD_INSERT,    64'h0000_0000_0000_0040, 0, 0, 0));  // no raise
    send_beat(pack_beat(CMD_INSERT,    64'h8000_0000_0000_003F, 0, 0, 0));  // top hash bit only
    send_beat(pack_beat(CMD_INSERT,    64'hFFFF_FFFF_FFFF_FFC1, 0, 0, 0));
    send_beat(pack_beat(CMD_MERGE,     64'd0, 5, 63, 0));      // rank too large: saturates
    send_beat(pack_beat(CMD_MERGE,     64'd0, 5, 0, 0));
    send_beat(pack_beat(CMD_MERGE,     64'd0, 62, 0, 0));      // zero onto zero
    send_beat(pack_beat(CMD_MERGE,     64'd0, 62, 59, 0));
    send_beat(pack_beat(CMD_MERGE,     64'd0, 62, 12, 0));
    send_beat(pack_beat(CMD_MERGE,     64'd0, 10, 1, 0));
    send_beat(pack_beat(CMD_MERGE,     64'd0, 63, 60, 0));
    send_beat(pack_beat(CMD_READ_SLOT, 64'd0, 63, 0, 0));
    send_beat(pack_beat(CMD_READ_SLOT, 64'd0, 5, 0, 0));
    send_beat(pack_beat(CMD_READ_SLOT, 64'd0, 0, 0, 0));
    send_beat(pack_beat(CMD_READ_BIN,  64'd0, 0, 0, 59));
    send_beat(pack_beat(CMD_READ_BIN,  64'd0, 0, 0, 58));
    send_beat(pack_beat(CMD_READ_BIN,  64'd0, 0, 0, 1));
    send_beat(pack_beat(CMD_READ_BIN,  64'd0, 0, 0, 0));
    send_beat(pack_beat(CMD_READ_BIN,  64'd0, 0, 0, 60));      // past the last bin
    send_beat(pack_beat(CMD_READ_BIN,  64'd0, 0, 0, 63));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PAUSE_AT) begin
        // let the block drain completely before going on
        cmd_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      send_beat(random_beat());
    end
    cmd_valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS hyperloglog_sketch_update");
    end else begin
      $display("FAIL hyperloglog_sketch_update");
    end
    $finish;
  end

endmodule
